FILE: rtl/core/minimum_spanning_tree_kruskal_unit_macros.svh
// ----------------------------------------------------------------------------
// MST unit assertion macros
// Implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_UNIT_MACROS_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define MST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define MST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/mst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MST package
// Shared widths and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int VERT_W = 6;
    localparam int CFG_W  = 7;
    localparam int RANK_W = 3;
    localparam logic [CFG_W-1:0] VCOUNT_RST = 7'd64;

    typedef struct packed {
        logic load;
        logic run_start;
        logic init_wr;
        logic scan_start;
        logic scan_step;
        logic pick;
        logic find_src;
        logic find_dst;
        logic find_step;
        logic found;
        logic rd_y;
        logic comp_wr;
        logic join_roots;
        logic emit_start;
        logic out_load;
        logic out_next;
        logic run_end;
    } t_dp_cmd;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic have_best;
        logic best_bad;
        logic tree_full;
        logic pd_eq_x;
        logic comp_done;
        logic sel_dst;
        logic out_acc;
        logic out_last;
    } t_dp_sts;

endpackage

FILE: rtl/core/mst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MST controller
// Sequences load, forest init, ordered scan, find/compress, join and emit.
// ----------------------------------------------------------------------------
module mst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_final_edge,
    input  mst_pkg::t_dp_sts  i_sts,
    output mst_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import mst_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_SCAN, S_PICK, S_F_RD, S_F_CHK,
        S_C_RD, S_C_WR, S_JOIN, S_E_RD, S_E_LD, S_E_WAIT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_final_edge) begin
                        o_cmd.run_start = 1'b1;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.tree_full || !i_sts.have_best) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = S_E_RD;
                end else begin
                    o_cmd.pick = 1'b1;
                    if (i_sts.best_bad) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.find_src = 1'b1;
                        n_state = S_F_RD;
                    end
                end
            end
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (i_sts.pd_eq_x) begin
                    o_cmd.found = 1'b1;
                    n_state = S_C_RD;
                end else begin
                    o_cmd.find_step = 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_C_RD: begin
                o_cmd.rd_y = 1'b1;
                if (i_sts.comp_done) begin
                    if (i_sts.sel_dst) begin
                        n_state = S_JOIN;
                    end else begin
                        o_cmd.find_dst = 1'b1;
                        n_state = S_F_RD;
                    end
                end else begin
                    n_state = S_C_WR;
                end
            end
            S_C_WR: begin
                o_cmd.comp_wr = 1'b1;
                n_state = S_C_RD;
            end
            S_JOIN: begin
                o_cmd.join_roots = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state = S_SCAN;
            end
            S_E_RD: begin
                n_state = S_E_LD;
            end
            S_E_LD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_E_WAIT;
            end
            S_E_WAIT: begin
                if (i_sts.out_acc) begin
                    if (i_sts.out_last) begin
                        o_cmd.run_end = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/mst_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MST datapath
// Edge store, ordered-scan registers, union-find memories, result buffer.
// ----------------------------------------------------------------------------
module mst_dpath #(
    parameter int MAX_EDGES    = 256,
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mst_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [mst_pkg::VERT_W-1:0]  i_edge_source,
    input  logic [mst_pkg::VERT_W-1:0]  i_edge_target,
    input  logic [WEIGHT_BITS-1:0]      i_edge_weight,
    input  logic                        i_out_stall,
    input  mst_pkg::t_dp_cmd            i_cmd,
    output mst_pkg::t_dp_sts            o_sts,
    output logic                        o_out_valid,
    output logic [mst_pkg::VERT_W-1:0]  o_tree_source,
    output logic [mst_pkg::VERT_W-1:0]  o_tree_target,
    output logic [WEIGHT_BITS-1:0]      o_tree_weight,
    output logic                        o_edge_valid,
    output logic                        o_last_result,
    output logic                        o_input_dropped
);
    import mst_pkg::*;

    localparam int EIDX = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FW   = $clog2(MAX_EDGES + 1);
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int EW   = 2 * VERT_W + WEIGHT_BITS;

    logic [EW-1:0]          mem_edge [MAX_EDGES];
    logic [EW-1:0]          mem_res  [MAX_VERTICES];
    logic [VW-1:0]          mem_par  [MAX_VERTICES];
    logic [RANK_W-1:0]      mem_rank [MAX_VERTICES];

    logic [CFG_W-1:0]       r_vcount;
    logic [FW-1:0]          r_fill;
    logic                   r_dropped;
    logic                   r_out_valid;

    logic [FW-1:0]          r_ptr;
    logic                   r_rd_vld;
    logic [EIDX-1:0]        r_rd_idx;
    logic [EW-1:0]          r_edata;
    logic                   r_have_best;
    logic [EW-1:0]          r_best;
    logic [EIDX-1:0]        r_best_idx;
    logic                   r_have_last;
    logic [WEIGHT_BITS-1:0] r_last_w;
    logic [EIDX-1:0]        r_last_idx;

    logic [VW-1:0]          r_cnt;
    logic [VW-1:0]          r_chosen;
    logic [VW-1:0]          r_x;
    logic [VW-1:0]          r_y;
    logic [VW-1:0]          r_orig;
    logic [VW-1:0]          r_root;
    logic [VW-1:0]          r_ra;
    logic [VW-1:0]          r_rb;
    logic                   r_sel;
    logic [VW-1:0]          r_pdata;
    logic [RANK_W-1:0]      r_rka;
    logic [RANK_W-1:0]      r_rkb;
    logic [VW-1:0]          r_k;
    logic [EW-1:0]          r_rdata;

    logic [CFG_W-1:0]       v_eff;
    logic                   load_ok;
    logic [VERT_W-1:0]      c_src, c_dst, b_src, b_dst;
    logic [WEIGHT_BITS-1:0] c_w, b_w;
    logic                   after_last, before_best;
    logic [VW-1:0]          par_addr;
    logic                   out_acc;

    always_comb begin
        if (r_vcount == '0) begin
            v_eff = CFG_W'(1);
        end else if (r_vcount > CFG_W'(MAX_VERTICES)) begin
            v_eff = CFG_W'(MAX_VERTICES);
        end else begin
            v_eff = r_vcount;
        end
    end

    assign load_ok = (CFG_W'(i_edge_source) < v_eff) && (CFG_W'(i_edge_target) < v_eff)
                     && (r_fill < FW'(MAX_EDGES));

    assign {c_src, c_dst, c_w} = r_edata;
    assign {b_src, b_dst, b_w} = r_best;

    // ordering key: signed weight, then arrival index
    assign after_last  = !r_have_last || ($signed(r_last_w) < $signed(c_w))
                         || ((r_last_w == c_w) && (r_last_idx < r_rd_idx));
    assign before_best = !r_have_best || ($signed(c_w) < $signed(b_w))
                         || ((c_w == b_w) && (r_rd_idx < r_best_idx));

    assign par_addr = i_cmd.rd_y ? r_y : r_x;
    assign out_acc  = r_out_valid && !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= VCOUNT_RST;
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (load_ok) begin
                    r_fill <= r_fill + FW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.pick && o_sts.best_bad) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.run_end) begin
                r_fill    <= '0;
                r_dropped <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            mem_edge[r_fill[EIDX-1:0]] <= {i_edge_source, i_edge_target, i_edge_weight};
        end
        r_edata <= mem_edge[r_ptr[EIDX-1:0]];
    end

    // ordered scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_have_last <= 1'b0;
            r_chosen    <= '0;
            r_cnt       <= '0;
        end
        if (i_cmd.init_wr) begin
            r_cnt <= r_cnt + VW'(1);
        end
        if (i_cmd.scan_start) begin
            r_ptr       <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_vld <= (r_ptr < r_fill);
            r_rd_idx <= r_ptr[EIDX-1:0];
            if (r_ptr < r_fill) begin
                r_ptr <= r_ptr + FW'(1);
            end
            if (r_rd_vld && after_last && before_best) begin
                r_have_best <= 1'b1;
                r_best      <= r_edata;
                r_best_idx  <= r_rd_idx;
            end
        end
        if (i_cmd.pick) begin
            r_have_last <= 1'b1;
            r_last_w    <= b_w;
            r_last_idx  <= r_best_idx;
        end
        if (i_cmd.find_src) begin
            r_x    <= b_src[VW-1:0];
            r_orig <= b_src[VW-1:0];
            r_sel  <= 1'b0;
        end
        if (i_cmd.find_dst) begin
            r_x    <= b_dst[VW-1:0];
            r_orig <= b_dst[VW-1:0];
            r_sel  <= 1'b1;
        end
        if (i_cmd.find_step) begin
            r_x <= r_pdata;
        end
        if (i_cmd.found) begin
            r_root <= r_x;
            r_y    <= r_orig;
            if (r_sel) begin
                r_rb <= r_x;
            end else begin
                r_ra <= r_x;
            end
        end
        if (i_cmd.comp_wr) begin
            r_y <= r_pdata;
        end
        if (i_cmd.join_roots && (r_ra != r_rb)) begin
            r_chosen <= r_chosen + VW'(1);
        end
        if (i_cmd.emit_start) begin
            r_k <= '0;
        end
        if (i_cmd.out_next) begin
            r_k <= r_k + VW'(1);
        end
    end

    // union-find forest
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr) begin
            mem_par[r_cnt]  <= r_cnt;
            mem_rank[r_cnt] <= '0;
        end else if (i_cmd.comp_wr) begin
            mem_par[r_y] <= r_root;
        end else if (i_cmd.join_roots && (r_ra != r_rb)) begin
            if (r_rka < r_rkb) begin
                mem_par[r_ra] <= r_rb;
            end else if (r_rka > r_rkb) begin
                mem_par[r_rb] <= r_ra;
            end else begin
                mem_par[r_rb]  <= r_ra;
                mem_rank[r_ra] <= r_rka + RANK_W'(1);
            end
        end
        r_pdata <= mem_par[par_addr];
        r_rka   <= mem_rank[r_ra];
        r_rkb   <= mem_rank[r_rb];
    end

    // result buffer and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.join_roots && (r_ra != r_rb)) begin
            mem_res[r_chosen] <= r_best;
        end
        r_rdata <= mem_res[r_k];
        if (i_cmd.out_load) begin
            if (r_chosen == '0) begin
                {o_tree_source, o_tree_target, o_tree_weight} <= '0;
            end else begin
                {o_tree_source, o_tree_target, o_tree_weight} <= r_rdata;
            end
            o_edge_valid    <= (r_chosen != '0);
            o_last_result   <= o_sts.out_last;
            o_input_dropped <= r_dropped;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.init_done = (r_cnt == VW'(MAX_VERTICES - 1));
        o_sts.scan_done = (r_ptr >= r_fill) && !r_rd_vld;
        o_sts.have_best = r_have_best;
        o_sts.best_bad  = (CFG_W'(b_src) >= v_eff) || (CFG_W'(b_dst) >= v_eff);
        o_sts.tree_full = (CFG_W'(r_chosen) + CFG_W'(1)) >= v_eff;
        o_sts.pd_eq_x   = (r_pdata == r_x);
        o_sts.comp_done = (r_y == r_root);
        o_sts.sel_dst   = r_sel;
        o_sts.out_acc   = out_acc;
        o_sts.out_last  = (CFG_W'(r_k) + CFG_W'(1)) >= CFG_W'(r_chosen);
    end

endmodule

FILE: rtl/core/minimum_spanning_tree_kruskal_unit.sv
`timescale 1ns / 1ps
// Load: one edge item per cycle. Run after the final item: forest init, then per
// visited edge an ordered scan and a pick; an in-range edge then gets a find with
// path compression from its source, then from its target, and a join. Emit: each
// result is held until taken before the next. Throughput is set by the edge scan.
// Reset: synchronous, active low; vertex_count = 64, empty edge store, no clear pass.
// ----------------------------------------------------------------------------
// Minimum spanning tree unit
// Kruskal MST over loaded edges with union-find (rank, path compression).
// ----------------------------------------------------------------------------
`include "minimum_spanning_tree_kruskal_unit_macros.svh"

module minimum_spanning_tree_kruskal_unit #(
    parameter int MAX_EDGES    = 256,
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mst_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mst_pkg::VERT_W-1:0]  i_edge_source,
    input  logic [mst_pkg::VERT_W-1:0]  i_edge_target,
    input  logic [WEIGHT_BITS-1:0]      i_edge_weight,
    input  logic                        i_final_edge,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mst_pkg::VERT_W-1:0]  o_tree_source,
    output logic [mst_pkg::VERT_W-1:0]  o_tree_target,
    output logic [WEIGHT_BITS-1:0]      o_tree_weight,
    output logic                        o_edge_valid,
    output logic                        o_last_result,
    output logic                        o_input_dropped
);
    import mst_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_edge (i_final_edge),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall)
    );

    mst_dpath #(
        .MAX_EDGES    (MAX_EDGES),
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_edge_source   (i_edge_source),
        .i_edge_target   (i_edge_target),
        .i_edge_weight   (i_edge_weight),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_tree_source   (o_tree_source),
        .o_tree_target   (o_tree_target),
        .o_tree_weight   (o_tree_weight),
        .o_edge_valid    (o_edge_valid),
        .o_last_result   (o_last_result),
        .o_input_dropped (o_input_dropped)
    );

    `MST_ASSERT_IMP(a_no_load_while_emit, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `MST_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, o_out_valid && !o_edge_valid, o_last_result)
    `MST_ASSERT_NXT(a_ready_after_last, i_clk, i_rst_n,
                    o_out_valid && !i_out_stall && o_last_result, !o_in_stall)
    `MST_ASSERT_IMP(a_join_in_run, i_clk, i_rst_n, cmd.join_roots, !sts.tree_full)

endmodule
